// ----- rtl/core/wfr_pkg.sv -----
// Shared types and constants for the Wiegand frame receiver.
`default_nettype none

package wfr_pkg;

   localparam int STORE_W = 64;   // left-justified frame image handed to the emitter
   localparam int COUNT_W = 7;    // bit count, 0..64
   localparam int GAP_W   = 16;
   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 3;

   localparam logic [GAP_W-1:0] GAP_RESET = 16'd40000;

   // Input word kinds
   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_PULSE = 1'b1;

   // Closed frame handed from the assembler to the byte emitter
   typedef struct packed {
      logic               valid;
      logic [STORE_W-1:0] bits;
      logic [COUNT_W-1:0] count;
   } frame_close_type;

endpackage

`default_nettype wire

// ----- rtl/core/wiegand_frame_receiver.sv -----
// Top level of the Wiegand frame receiver.
//
// Input words (req_*) are either a time tick (req_type = 0) or a data pulse
// (req_type = 1, req_bit_value = D0/D1). Pulses append bits MSB-first up to
// MAX_BITS and restart the gap timer; ticks on an open frame advance it.
// When the timer reaches csr gap_ticks the frame closes and its bits come out
// on the rsp_* channel as bytes, earliest bit in the MSB, each with its index,
// the frame bit count and a last-byte flag.
// Throughput: one input word per cycle. The first byte of a frame is valid
// the cycle after the closing tick is accepted; bytes follow one per cycle
// while rsp_ready is high, up to 8 per frame, from the emitter's output
// registers. Pulses and non-closing ticks are taken while the emitter
// drains; a closing tick is held off (req_ready low) until the emitter can
// take the new frame, which is at the latest as its last byte is sent.
// Reset clears the frame and the emitter and sets gap_ticks to 40000.
// csr_write_en writes gap_ticks at once; write it only while idle.
`default_nettype none

module wiegand_frame_receiver #(
   parameter int MAX_BITS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_type,
   input  logic                          req_bit_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [wfr_pkg::BYTE_W-1:0]    rsp_data_byte,
   output logic [wfr_pkg::INDEX_W-1:0]   rsp_byte_index,
   output logic [wfr_pkg::COUNT_W-1:0]   rsp_frame_bit_count,
   output logic                          rsp_last_byte,
   input  logic                          csr_write_en,
   input  logic [wfr_pkg::GAP_W-1:0]     csr_write_data
);
   import wfr_pkg::*;

   frame_close_type close_word;
   logic            load_ready;

   // Assemble frames and detect the closing gap
   wfr_frame #(
      .MAX_BITS(MAX_BITS)
   ) u_frame (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_bit_value  (req_bit_value),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .load_ready     (load_ready),
      .close_out      (close_word)
   );

   // Stream the closed frame out as bytes
   wfr_emit u_emit (
      .clock               (clock),
      .reset               (reset),
      .close_in            (close_word),
      .load_ready          (load_ready),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_byte_index      (rsp_byte_index),
      .rsp_frame_bit_count (rsp_frame_bit_count),
      .rsp_last_byte       (rsp_last_byte)
   );

endmodule

`default_nettype wire

// ----- rtl/core/wfr_frame.sv -----
// Frame assembler: bit store, bit count, gap timer and gap register.
`default_nettype none

module wfr_frame #(
   parameter int MAX_BITS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_type,
   input  logic                          req_bit_value,
   input  logic                          csr_write_en,
   input  logic [wfr_pkg::GAP_W-1:0]     csr_write_data,
   input  logic                          load_ready,
   output wfr_pkg::frame_close_type      close_out
);
   import wfr_pkg::*;

   localparam int IDX_W = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;

   logic [MAX_BITS-1:0] store_ff, store_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [GAP_W-1:0]    gap_cnt_ff, gap_cnt_in;
   logic                open_ff, open_in;
   logic [GAP_W-1:0]    gap_ticks_ff;

   logic [GAP_W-1:0]    gap_next;
   logic                closes;
   logic                accept;
   logic                store_full;
   logic [IDX_W-1:0]    wr_idx;

   // Gap register; the user must write it only while idle, the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ticks_ff <= GAP_RESET;
      end else if (csr_write_en) begin
         gap_ticks_ff <= csr_write_data;
      end
   end

   // A tick on an open frame closes it once the count reaches the gap
   assign gap_next = gap_cnt_ff + GAP_W'(1);
   assign closes   = (req_type == REQ_TICK) && open_ff && !(gap_next < gap_ticks_ff);

   // Hold off a closing tick while the emitter still drains the previous frame
   assign req_ready = !closes || load_ready;
   assign accept    = req_valid && req_ready;

   assign store_full = !(count_ff < COUNT_W'(MAX_BITS));
   assign wr_idx     = IDX_W'(MAX_BITS - 1) - count_ff[IDX_W-1:0];

   // Next frame state
   always_comb begin
      store_in   = store_ff;
      count_in   = count_ff;
      gap_cnt_in = gap_cnt_ff;
      open_in    = open_ff;
      if (accept) begin
         if (req_type == REQ_PULSE) begin
            // Store the bit MSB-first unless full; any pulse restarts the gap
            if (!store_full) begin
               for (int i = 0; i < MAX_BITS; i++) begin
                  if (IDX_W'(i) == wr_idx) begin
                     store_in[i] = req_bit_value;
                  end
               end
               count_in = count_ff + COUNT_W'(1);
            end
            open_in    = 1'b1;
            gap_cnt_in = '0;
         end else if (open_ff) begin
            if (closes) begin
               store_in   = '0;
               count_in   = '0;
               gap_cnt_in = '0;
               open_in    = 1'b0;
            end else begin
               gap_cnt_in = gap_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff   <= '0;
         count_ff   <= '0;
         gap_cnt_ff <= '0;
         open_ff    <= 1'b0;
      end else begin
         store_ff   <= store_in;
         count_ff   <= count_in;
         gap_cnt_ff <= gap_cnt_in;
         open_ff    <= open_in;
      end
   end

   // Hand the left-justified frame to the emitter on the closing tick
   assign close_out.valid = accept && closes;
   assign close_out.bits  = STORE_W'(store_ff) << (STORE_W - MAX_BITS);
   assign close_out.count = count_ff;

endmodule

`default_nettype wire

// ----- rtl/core/wfr_emit.sv -----
// Byte emitter: holds a closed frame and sends it one byte per word.
`default_nettype none

module wfr_emit (
   input  logic                          clock,
   input  logic                          reset,
   input  wfr_pkg::frame_close_type      close_in,
   output logic                          load_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [wfr_pkg::BYTE_W-1:0]    rsp_data_byte,
   output logic [wfr_pkg::INDEX_W-1:0]   rsp_byte_index,
   output logic [wfr_pkg::COUNT_W-1:0]   rsp_frame_bit_count,
   output logic                          rsp_last_byte
);
   import wfr_pkg::*;

   logic [STORE_W-1:0] snap_ff, snap_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic [INDEX_W-1:0] last_idx_ff, last_idx_in;
   logic               busy_ff, busy_in;

   logic               is_last;
   logic               sent;
   logic [COUNT_W-1:0] count_m1;

   assign is_last    = (idx_ff == last_idx_ff);
   assign sent       = busy_ff && rsp_ready;
   assign load_ready = !busy_ff || (sent && is_last);

   // Last byte index is (count - 1) / 8; a frame always holds at least one bit
   assign count_m1 = close_in.count - COUNT_W'(1);

   // Load a new frame, otherwise advance on each sent word
   always_comb begin
      snap_in     = snap_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      last_idx_in = last_idx_ff;
      busy_in     = busy_ff;
      if (close_in.valid) begin
         snap_in     = close_in.bits;
         count_in    = close_in.count;
         idx_in      = '0;
         last_idx_in = count_m1[INDEX_W+2:3];
         busy_in     = 1'b1;
      end else if (sent) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            snap_in = snap_ff << BYTE_W;
            idx_in  = idx_ff + INDEX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff     <= snap_in;
      count_ff    <= count_in;
      idx_ff      <= idx_in;
      last_idx_ff <= last_idx_in;
   end

   // Drive the result word straight from registers
   assign rsp_valid           = busy_ff;
   assign rsp_data_byte       = snap_ff[STORE_W-1 -: BYTE_W];
   assign rsp_byte_index      = idx_ff;
   assign rsp_frame_bit_count = count_ff;
   assign rsp_last_byte       = is_last;

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for the Wiegand frame receiver: random words, byte-level checks.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wfr_pkg::*;

   localparam int FRAME_MAX      = 64;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_AFTER     = 40;    // bytes seen before the long receiver hold
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 12;    // settle time before a register write
   localparam int OPEN_TICKS     = 12;    // ticks well short of a large gap
   localparam logic [8:0] PULSE_PATTERN = 9'b101100101;

   typedef struct packed {
      logic kind;
      logic bitv;
   } pulse_word_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  data;
      logic [INDEX_W-1:0] index;
      logic [COUNT_W-1:0] count;
      logic               last;
   } frame_byte_type;

   logic                clock;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_ready;
   logic                req_type       = REQ_TICK;
   logic                req_bit_value  = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready      = 1'b0;
   logic [BYTE_W-1:0]   rsp_data_byte;
   logic [INDEX_W-1:0]  rsp_byte_index;
   logic [COUNT_W-1:0]  rsp_frame_bit_count;
   logic                rsp_last_byte;
   logic                csr_write_en   = 1'b0;
   logic [GAP_W-1:0]    csr_write_data = '0;

   wiegand_frame_receiver #(
      .MAX_BITS(FRAME_MAX)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type(req_type),
      .req_bit_value(req_bit_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data_byte(rsp_data_byte),
      .rsp_byte_index(rsp_byte_index),
      .rsp_frame_bit_count(rsp_frame_bit_count),
      .rsp_last_byte(rsp_last_byte),
      .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Words waiting to be sent and bytes the frame predictor expects
   pulse_word_type word_queue[$];
   frame_byte_type expected_bytes[$];
   int             n_errors = 0;

   // Frame predictor state
   logic [STORE_W-1:0] frm_bits  = '0;
   logic [COUNT_W-1:0] frm_count = '0;
   logic [GAP_W-1:0]   frm_gap   = '0;
   logic               frm_open  = 1'b0;
   logic [GAP_W-1:0]   gap_cfg   = GAP_RESET;

   // Generator view of the frame, used to close frames before register writes
   bit gen_open  = 1'b0;
   int gen_since = 0;
   int gen_gap   = GAP_RESET;
   int gen_items = 0;

   task automatic flag_mismatch(string what);
      n_errors++;
      $display("MISMATCH at %0t: %s", $realtime, what);
   endtask

   // Advance the predicted frame by one accepted word; queue the bytes of a closing tick
   task automatic absorb_word(logic kind, logic bitv);
      int n_out;
      frame_byte_type b;
      if (kind == REQ_PULSE) begin
         if (frm_count < FRAME_MAX) begin
            if (bitv) frm_bits[STORE_W - 1 - frm_count] = 1'b1;
            frm_count = frm_count + 1'b1;
         end
         frm_open = 1'b1;
         frm_gap  = '0;
      end else if (frm_open) begin
         frm_gap = frm_gap + 1'b1;
         if (frm_gap >= gap_cfg) begin
            n_out = (frm_count + 7) / 8;
            if (n_out > 8) n_out = 8;
            for (int k = 0; k < n_out; k++) begin
               b.data  = frm_bits[STORE_W - 1 - 8 * k -: 8];
               b.index = 3'(k);
               b.count = frm_count;
               b.last  = (k == n_out - 1);
               expected_bytes.push_back(b);
            end
            frm_bits  = '0;
            frm_count = '0;
            frm_gap   = '0;
            frm_open  = 1'b0;
         end
      end
   endtask

   // Pick the idle cycles before the next word: stretches of no idling alternate with random ones
   function automatic int draw_wait(inout int left, inout bit calm);
      if (left == 0) begin
         left = $urandom_range(1, 48);
         calm = ($urandom_range(0, 1) == 0);
      end
      left--;
      return calm ? 0 : $urandom_range(0, 11);
   endfunction

   // Driver: present queued words, idle between them
   int             tx_wait    = 0;
   int             tx_stretch = 0;
   bit             tx_calm    = 1'b0;
   pulse_word_type tx_word;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_wait = 0;
      end else begin
         if (req_valid && req_ready) begin
            absorb_word(req_type, req_bit_value);
            tx_wait = draw_wait(tx_stretch, tx_calm);
         end
         if (!req_valid || req_ready) begin
            if (tx_wait > 0) begin
               tx_wait--;
               req_valid <= 1'b0;
            end else if (word_queue.size() > 0) begin
               tx_word = word_queue.pop_front();
               req_valid     <= 1'b1;
               req_type      <= tx_word.kind;
               req_bit_value <= tx_word.bitv;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each byte against the oldest expectation, stall at random
   int             rx_wait    = 0;
   int             rx_stretch = 0;
   bit             rx_calm    = 1'b0;
   int             hold_left  = 0;
   int             n_bytes    = 0;
   frame_byte_type rx_exp;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_wait   = 0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               flag_mismatch($sformatf("unexpected byte %02h index %0d count %0d last %0b",
                  rsp_data_byte, rsp_byte_index, rsp_frame_bit_count, rsp_last_byte));
            end else begin
               rx_exp = expected_bytes.pop_front();
               if (rsp_data_byte !== rx_exp.data || rsp_byte_index !== rx_exp.index ||
                   rsp_frame_bit_count !== rx_exp.count || rsp_last_byte !== rx_exp.last) begin
                  flag_mismatch($sformatf(
                     "got byte %02h idx %0d cnt %0d last %0b, want %02h idx %0d cnt %0d last %0b",
                     rsp_data_byte, rsp_byte_index, rsp_frame_bit_count, rsp_last_byte,
                     rx_exp.data, rx_exp.index, rx_exp.count, rx_exp.last));
               end
            end
            n_bytes++;
            rx_wait = draw_wait(rx_stretch, rx_calm);
            if (n_bytes == HOLD_AFTER) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rx_wait > 0) begin
            rx_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   int idle_run = 0;

   initial begin
      while (idle_run < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_run = 0;
         else idle_run++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // Queue one word and track whether it leaves a frame open
   task automatic push_word(logic kind, logic bitv);
      pulse_word_type w;
      w.kind = kind;
      w.bitv = bitv;
      word_queue.push_back(w);
      if (kind == REQ_PULSE) begin
         gen_open  = 1'b1;
         gen_since = 0;
         gen_items++;
      end else if (gen_open) begin
         gen_since++;
         gen_items++;
         if (gen_since >= gen_gap) gen_open = 1'b0;
      end
   endtask

   task automatic push_tick();
      push_word(REQ_TICK, 1'($urandom_range(0, 1)));
   endtask

   task automatic close_frame();
      while (gen_open) push_tick();
   endtask

   // Send a frame of len pulses; style 0 random, 1 all D1, 2 all D0, 3 alternating
   task automatic push_frame(int len, int style, bit gappy);
      logic b;
      for (int i = 0; i < len; i++) begin
         case (style)
            1: b = 1'b1;
            2: b = 1'b0;
            3: b = 1'(i);
            default: b = 1'($urandom_range(0, 1));
         endcase
         push_word(REQ_PULSE, b);
         // Insert ticks short of the gap so the frame stays open
         if (gen_gap > 1 && (gappy || $urandom_range(0, 7) == 0)) begin
            repeat ($urandom_range(1, gen_gap - 1)) push_tick();
         end
      end
   endtask

   // Drain the block, then write the gap register
   task automatic set_gap(logic [GAP_W-1:0] v);
      @(negedge clock);
      while (word_queue.size() > 0 || req_valid || expected_bytes.size() > 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en <= 1'b0;
      gap_cfg = v;
      gen_gap = (v == 0) ? 1 : v;
      @(negedge clock);
   endtask

   // Mix of well-formed frames, idle noise and broken frames under one gap setting
   task automatic run_random(logic [GAP_W-1:0] v, int n_items);
      int pick;
      set_gap(v);
      gen_items = 0;
      while (gen_items < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            if ($urandom_range(0, 9) == 0) push_frame($urandom_range(60, 72),
                                                     $urandom_range(0, 3), 1'b0);
            else push_frame($urandom_range(1, 24), ($urandom_range(0, 4) == 0) ?
                            $urandom_range(1, 3) : 0, 1'b0);
            close_frame();
         end else if (pick < 85) begin
            close_frame();
            repeat ($urandom_range(1, 4)) push_tick();
         end else begin
            push_frame($urandom_range(2, 12), 0, 1'b1);
            if ($urandom_range(0, 1) == 0) close_frame();
         end
      end
      close_frame();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset gap value: an idle tick, a short frame, then ticks well short of the gap
      push_word(REQ_TICK, 1'b1);
      push_word(REQ_PULSE, 1'b1);
      push_word(REQ_PULSE, 1'b0);
      push_word(REQ_PULSE, 1'b1);
      repeat (OPEN_TICKS) push_tick();
      push_word(REQ_TICK, 1'b0);

      // Gap of zero closes the open frame on the first tick
      set_gap('0);
      push_word(REQ_PULSE, 1'b1);
      push_word(REQ_TICK, 1'b0);
      push_word(REQ_TICK, 1'b1);
      for (int i = 0; i < 9; i++) push_word(REQ_PULSE, PULSE_PATTERN[8 - i]);
      push_word(REQ_TICK, 1'b1);

      // Largest gap; a pulse in the middle restarts the counter and the frame stays open
      set_gap('1);
      push_word(REQ_PULSE, 1'b0);
      repeat (OPEN_TICKS) push_tick();
      push_word(REQ_PULSE, 1'b1);
      repeat (OPEN_TICKS) push_tick();

      run_random(16'd1, 80);
      run_random(16'd2, 80);
      run_random(GAP_W'($urandom_range(3, 9)), 80);
      run_random(16'd16, 80);

      // Wait for every expected byte, then watch for stray ones
      @(negedge clock);
      while (word_queue.size() > 0 || req_valid || expected_bytes.size() > 0) @(negedge clock);
      repeat (40) @(posedge clock);
      if (n_errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
